// ===== sv/tfm_pkg.sv =====
`default_nettype none

package tfm_pkg;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TOPIC  = 2'd2
    } action_t;

    // special bytes of a topic filter
    localparam logic [7:0] SEP_CHAR   = 8'h2F;
    localparam logic [7:0] LEVEL_CHAR = 8'h2B;
    localparam logic [7:0] REST_CHAR  = 8'h23;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 8;

endpackage

`default_nettype wire

// ===== sv/topic_filter_matcher_unit.sv =====
// channel  | valid/ready      | tdata bits (low first) | tuser bits     | tlast
// ---------+------------------+------------------------+----------------+-----------
// input    | s_tvalid/tready  | data_byte[7:0]         | action[1:0]    | topic_last
// result   | m_tvalid/tready  | matched[0]             | -              | -
//
// one item per cycle while the input is not stalled, clear, append and topic bytes alike;
// a result appears in the cycle after the transfer of the final topic byte
// the filter sits in one ram; each topic byte compares against a register
// holding the filter byte at the current position, while the ram prefetches
// the byte after it, so a step is one compare and one ram read
// reset is synchronous on aresetn and empties the filter at once
// input stalls only while a result waits in the output register

`default_nettype none

module topic_filter_matcher_unit
    import tfm_pkg::*;
#(
    parameter int unsigned FILTER_BYTES = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // data_byte[7:0]
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // action[1:0]
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata    // matched[0], zeros
);

    localparam int unsigned AW = $clog2(FILTER_BYTES);
    localparam int unsigned LW = $clog2(FILTER_BYTES + 1);
    localparam logic [LW-1:0] FULL_LEN = LW'(FILTER_BYTES);

    // input decode
    logic       in_xfer;
    action_t    action;
    logic [7:0] in_byte;

    assign s_tready = !m_tvalid || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser);
    assign in_byte  = s_tdata;

    // state
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic          lvl_reg, lvl_next;
    logic          rest_reg, rest_next;
    logic          mis_reg, mis_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    cur_reg, cur_next;
    logic [7:0]    head_reg, head_next;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic          out_valid_reg, out_valid_next;
    logic          out_match_reg, out_match_next;

    // filter ram
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    nxt_byte;

    tfm_ram #(
        .WIDTH(8),
        .DEPTH(FILTER_BYTES)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(in_byte),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // byte after the current position, with bypass of a same-cycle write
    assign nxt_byte = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_addr  = len_reg[AW-1:0];
    assign wr_en    = in_xfer && (action == ACT_APPEND) && (len_reg < FULL_LEN);
    assign rd_addr  = AW'(pos_next + LW'(1));

    // match step
    logic          cur_end;
    logic          nxt_end;
    logic          step;
    logic          bad;
    logic          adv;
    logic [LW-1:0] pos_inc;

    always_comb begin
        pos_inc = pos_reg + LW'(1);
        cur_end = (pos_reg >= len_reg) || (cur_reg == NUL_CHAR);
        nxt_end = (pos_inc >= len_reg) || (nxt_byte == NUL_CHAR);
        step    = !mis_reg && !rest_reg && (!lvl_reg || in_byte == SEP_CHAR);
        bad     = cur_end
                  || (in_byte == SEP_CHAR && cur_reg != SEP_CHAR)
                  || (cur_reg != LEVEL_CHAR && cur_reg != REST_CHAR
                      && cur_reg != in_byte);
        adv     = step && !bad;
    end

    // next state
    always_comb begin
        len_next       = len_reg;
        pos_next       = pos_reg;
        lvl_next       = lvl_reg;
        rest_next      = rest_reg;
        mis_next       = mis_reg;
        ovf_next       = ovf_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_match_next = out_match_reg;
        if (in_xfer) begin
            case (action)
                ACT_CLEAR: begin
                    len_next  = '0;
                    ovf_next  = 1'b0;
                    pos_next  = '0;
                    lvl_next  = 1'b0;
                    rest_next = 1'b0;
                    mis_next  = 1'b0;
                    cur_next  = head_reg;
                end
                ACT_APPEND: begin
                    if (len_reg < FULL_LEN) begin
                        len_next = len_reg + LW'(1);
                        if (len_reg == '0) begin
                            head_next = in_byte;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    pos_next  = '0;
                    lvl_next  = 1'b0;
                    rest_next = 1'b0;
                    mis_next  = 1'b0;
                    cur_next  = head_next;
                end
                ACT_TOPIC: begin
                    if (step) begin
                        lvl_next = 1'b0;
                        if (bad) begin
                            mis_next = 1'b1;
                        end else begin
                            lvl_next  = (cur_reg == LEVEL_CHAR);
                            rest_next = (cur_reg == REST_CHAR);
                            pos_next  = pos_inc;
                            cur_next  = nxt_byte;
                        end
                    end
                    if (s_tlast) begin
                        out_valid_next = 1'b1;
                        out_match_next = !mis_next && !ovf_reg && (adv ? nxt_end : cur_end);
                        pos_next       = '0;
                        lvl_next       = 1'b0;
                        rest_next      = 1'b0;
                        mis_next       = 1'b0;
                        cur_next       = head_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            pos_reg       <= '0;
            lvl_reg       <= 1'b0;
            rest_reg      <= 1'b0;
            mis_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            lvl_reg       <= lvl_next;
            rest_reg      <= rest_next;
            mis_reg       <= mis_next;
            ovf_reg       <= ovf_next;
            fwd_hit_reg   <= wr_en && (wr_addr == rd_addr);
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        head_reg      <= head_next;
        fwd_data_reg  <= in_byte;
        out_match_reg <= out_match_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 1){1'b0}}, out_match_reg};

    // checks
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= FULL_LEN)
        else $error("filter length beyond capacity");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= len_reg)
        else $error("position past filter length");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (len_reg == FULL_LEN))
        else $error("overflow with room left");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && action == ACT_TOPIC && s_tlast) |=> m_tvalid)
        else $error("final topic byte gave no result");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && action == ACT_CLEAR) |=> (len_reg == '0 && pos_reg == '0 && !ovf_reg))
        else $error("clear left filter state");

endmodule

`default_nettype wire

// ===== sv/tfm_ram.sv =====
`default_nettype none

module tfm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ===== tb/tb_topic_filter_matcher_unit.sv =====
`timescale 1ns / 100ps

module tb_topic_filter_matcher_unit;
    import tfm_pkg::*;

    localparam int unsigned FILTER_DEPTH = 64;
    localparam int unsigned ITEM_TARGET  = 1950;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 400;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned MAX_REPORTS  = 10;

    // the one action code the block does not use
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // shadow of the matcher: stored filter, topic progress, pending match bits
    class match_scoreboard;
        logic [7:0]  stored_filter [FILTER_DEPTH];
        int unsigned stored_len;
        int unsigned topic_pos;
        bit          level_skip;
        bit          rest_skip;
        bit          topic_failed;
        bit          filter_overflowed;
        bit          expected_match [$];
        int unsigned mismatches;
        int unsigned transfers;
        int unsigned topics;
        int unsigned topic_hits;
        int unsigned overflow_topics;

        function new();
            stored_len        = 0;
            filter_overflowed = 0;
            restart_topic();
        endfunction

        function void restart_topic();
            topic_pos    = 0;
            level_skip   = 0;
            rest_skip    = 0;
            topic_failed = 0;
        endfunction

        // filter ends at its length, at capacity or at a stored zero byte
        function bit filter_done(int unsigned pos);
            if (pos >= stored_len || pos >= FILTER_DEPTH)
                return 1'b1;
            return stored_filter[pos] == NUL_CHAR;
        endfunction

        // update the shadow state for one accepted input transfer
        function void note_transfer(logic [1:0] act, logic [7:0] b, bit last);
            logic [7:0] f;
            bit         hit;
            transfers++;
            case (act)
                ACT_CLEAR: begin
                    stored_len        = 0;
                    filter_overflowed = 0;
                    restart_topic();
                end
                ACT_APPEND: begin
                    if (stored_len < FILTER_DEPTH) begin
                        stored_filter[stored_len] = b;
                        stored_len++;
                    end else begin
                        filter_overflowed = 1;
                    end
                    restart_topic();
                end
                ACT_TOPIC: begin
                    if (!topic_failed && !rest_skip) begin
                        // a separator closes a single-level wildcard
                        if (level_skip && b == SEP_CHAR)
                            level_skip = 0;
                        if (!level_skip) begin
                            if (filter_done(topic_pos)) begin
                                topic_failed = 1;
                            end else begin
                                f = stored_filter[topic_pos];
                                if ((b == SEP_CHAR && f != SEP_CHAR) ||
                                    (f != LEVEL_CHAR && f != REST_CHAR && f != b)) begin
                                    topic_failed = 1;
                                end else begin
                                    if (f == LEVEL_CHAR)
                                        level_skip = 1;
                                    else if (f == REST_CHAR)
                                        rest_skip = 1;
                                    topic_pos++;
                                end
                            end
                        end
                    end
                    if (last) begin
                        hit = !topic_failed && !filter_overflowed && filter_done(topic_pos);
                        expected_match.push_back(hit);
                        topics++;
                        if (hit)
                            topic_hits++;
                        if (filter_overflowed)
                            overflow_topics++;
                        restart_topic();
                    end
                end
                default: ;
            endcase
        endfunction

        // compare one result transfer against the oldest pending match bit
        function void check_match(logic got);
            bit want;
            if (expected_match.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: matched=%b, nothing pending", $time, got);
            end else begin
                want = expected_match.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] matched mismatch: expected %0d, got %b",
                                 $time, want, got);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_match.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // data_byte[7:0]
    logic [IN_USER_W-1:0]  s_tuser  = '0;   // action[1:0]
    logic                  s_tlast  = 1'b0; // topic_last
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // matched[0], zeros

    match_scoreboard sb;
    logic [7:0]      filter_text [$];
    logic [7:0]      topic_text [$];
    int unsigned     items_sent;
    int unsigned     burst_left;
    int unsigned     cycle_count;
    bit              hold_req;
    bit              hold_done;

    topic_filter_matcher_unit #(
        .FILTER_BYTES(FILTER_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_match(m_tdata[0]);
    end

    // receiver: changing stall patterns plus one long hold-off
    initial begin
        int unsigned mode_left;
        int unsigned rdy_mode;
        int unsigned phase;
        bit          rdy;
        mode_left = 0;
        phase     = 0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1;
            end else begin
                if (mode_left == 0) begin
                    rdy_mode  = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (rdy_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (phase % 3 == 0);
                    default: rdy = ($urandom_range(0, 15) != 0);
                endcase
                m_tready <= rdy;
                @(posedge aclk);
            end
        end
    end

    // offer one input transfer, with random gaps between bursts
    task automatic send_item(logic [1:0] act, logic [7:0] b, bit last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= act;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_transfer(act, b, last);
        burst_left--;
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // send a string with one action; close marks the final byte as last
    task automatic send_text(logic [1:0] act, string s, bit close);
        for (int i = 0; i < s.len(); i++)
            send_item(act, s[i], close && (i == s.len() - 1));
    endtask

    // send the first upto bytes of the current topic
    task automatic send_topic(int unsigned upto);
        for (int i = 0; i < upto; i++)
            send_item(ACT_TOPIC, topic_text[i], i == topic_text.size() - 1);
    endtask

    function automatic logic [7:0] pick_char();
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    // build a filter from levels; long_len > 0 asks for a long literal-heavy one
    function automatic void make_filter(int unsigned long_len);
        int unsigned nlev;
        int unsigned n;
        filter_text.delete();
        nlev = $urandom_range(1, 4);
        for (int lev = 0; (long_len == 0) ? lev < nlev : filter_text.size() < long_len;
             lev++) begin
            if (lev > 0)
                filter_text.push_back(SEP_CHAR);
            if (long_len == 0 && lev == nlev - 1 && $urandom_range(0, 3) == 0) begin
                filter_text.push_back(REST_CHAR);
            end else if ($urandom_range(0, 3) == 0) begin
                filter_text.push_back(LEVEL_CHAR);
            end else begin
                n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                repeat (n) filter_text.push_back(pick_char());
            end
        end
        while (long_len != 0 && filter_text.size() > long_len)
            void'(filter_text.pop_back());
        // an embedded zero byte cuts the filter short
        if (long_len == 0 && $urandom_range(0, 11) == 0)
            filter_text.insert($urandom_range(0, filter_text.size()), NUL_CHAR);
    endfunction

    function automatic void n_trim(int unsigned sz);
        int unsigned keep;
        keep = $urandom_range(1, sz);
        while (topic_text.size() > keep)
            void'(topic_text.pop_back());
    endfunction

    // derive a topic that fits the filter, then sometimes break it
    function automatic void make_topic();
        int unsigned sz;
        topic_text.delete();
        for (int i = 0; i < filter_text.size() && i < FILTER_DEPTH &&
                        filter_text[i] != NUL_CHAR; i++) begin
            if (filter_text[i] == LEVEL_CHAR) begin
                repeat ($urandom_range(1, 3)) topic_text.push_back(pick_char());
            end else if (filter_text[i] == REST_CHAR) begin
                topic_text.push_back(pick_char());
                repeat ($urandom_range(0, 4))
                    topic_text.push_back(($urandom_range(0, 2) == 0) ? SEP_CHAR : pick_char());
            end else begin
                topic_text.push_back(filter_text[i]);
            end
        end
        sz = topic_text.size();
        if (sz > 0 && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    case ($urandom_range(0, 4))
                        0:       topic_text[$urandom_range(0, sz - 1)] = SEP_CHAR;
                        1:       topic_text[$urandom_range(0, sz - 1)] = LEVEL_CHAR;
                        2:       topic_text[$urandom_range(0, sz - 1)] = REST_CHAR;
                        3:       topic_text[$urandom_range(0, sz - 1)] = pick_char();
                        default: topic_text[$urandom_range(0, sz - 1)] = 8'($urandom);
                    endcase
                end
                1: void'(topic_text.pop_back());
                2: topic_text.push_back(($urandom_range(0, 1) == 0) ? SEP_CHAR : pick_char());
                default: begin
                    n_trim(sz);
                end
            endcase
        end
        if (topic_text.size() == 0)
            topic_text.push_back(8'($urandom));
    endfunction

    // stimulus
    initial begin
        int unsigned seq_no;
        int unsigned long_len;
        int unsigned cut;
        sb = new();
        items_sent  = 0;
        burst_left  = 0;
        cycle_count = 0;
        hold_req    = 0;
        hold_done   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // topic against the empty filter after reset
        send_item(ACT_TOPIC, 8'hFF, 1'b1);
        // wildcards: '+' needs a non-separator byte, '#' needs at least one byte
        send_item(ACT_CLEAR, 8'hFF, 1'b1);
        send_text(ACT_APPEND, "+/#", 1'b0);
        send_text(ACT_TOPIC, "x/y", 1'b1);
        send_text(ACT_TOPIC, "/", 1'b1);
        send_text(ACT_TOPIC, "x/", 1'b1);
        // unused action code is ignored
        send_item(ACT_UNUSED, 8'hA5, 1'b1);
        // zero byte ends the filter
        send_item(ACT_CLEAR, 8'h00, 1'b0);
        send_item(ACT_APPEND, "a", 1'b0);
        send_item(ACT_APPEND, NUL_CHAR, 1'b1);
        send_text(ACT_TOPIC, "a", 1'b1);
        // filter change in the middle of a topic abandons it
        send_text(ACT_TOPIC, "a", 1'b0);
        send_item(ACT_APPEND, "b", 1'b0);
        send_text(ACT_TOPIC, "a", 1'b1);
        // topic longer than the filter
        send_text(ACT_TOPIC, "ab", 1'b1);

        // random sequences: clear, build a filter, stream several topics
        seq_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= HOLD_AFTER)
                hold_req = 1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            if (seq_no == 3)
                long_len = FILTER_DEPTH;
            else if (seq_no == 6)
                long_len = FILTER_DEPTH + 2;
            else if ($urandom_range(0, 11) == 0)
                long_len = $urandom_range(FILTER_DEPTH - 4, FILTER_DEPTH + 6);
            else
                long_len = 0;
            make_filter(long_len);
            send_item(ACT_CLEAR, 8'($urandom), 1'($urandom));
            foreach (filter_text[i])
                send_item(ACT_APPEND, filter_text[i], 1'($urandom));
            repeat ($urandom_range(1, 6)) begin
                make_topic();
                if (topic_text.size() > 1 && $urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(1, topic_text.size() - 1);
                    send_topic(cut);
                    filter_text.push_back(pick_char());
                    send_item(ACT_APPEND, filter_text[filter_text.size() - 1], 1'($urandom));
                end else begin
                    send_topic(topic_text.size());
                end
            end
            seq_no++;
        end
        s_tvalid <= 1'b0;

        // drain
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d transfers in %0d filter runs: %0d topics, %0d matching",
                 sb.transfers, seq_no, sb.topics, sb.topic_hits);
        $display("%0d topics on an overflowed filter, long hold-off done: %0d, %0d mismatches",
                 sb.overflow_topics, hold_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
